@@ sv/mips_dec_pkg.sv @@
// ----------------------------------------------------------------------------
// mips_dec_pkg
// Types and encodings shared by the instruction decoder.
// ----------------------------------------------------------------------------
package mips_dec_pkg;

    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,
        OP_ADDU  = 6'd1,
        OP_SUB   = 6'd2,
        OP_AND   = 6'd3,
        OP_OR    = 6'd4,
        OP_XOR   = 6'd5,
        OP_NOR   = 6'd6,
        OP_NAND  = 6'd7,
        OP_SLT   = 6'd8,
        OP_SLL   = 6'd9,
        OP_NOP   = 6'd10,
        OP_SRL   = 6'd11,
        OP_SRA   = 6'd12,
        OP_JR    = 6'd13,
        OP_MULT  = 6'd14,
        OP_MULTU = 6'd15,
        OP_MFHI  = 6'd16,
        OP_MFLO  = 6'd17,
        OP_JUMP  = 6'd18,
        OP_JAL   = 6'd19,
        OP_HALT  = 6'd20,
        OP_ADDI  = 6'd21,
        OP_ADDIU = 6'd22,
        OP_LW    = 6'd23,
        OP_LH    = 6'd24,
        OP_LHU   = 6'd25,
        OP_LB    = 6'd26,
        OP_LBU   = 6'd27,
        OP_SW    = 6'd28,
        OP_SH    = 6'd29,
        OP_SB    = 6'd30,
        OP_LUI   = 6'd31,
        OP_ANDI  = 6'd32,
        OP_ORI   = 6'd33,
        OP_NORI  = 6'd34,
        OP_SLTI  = 6'd35,
        OP_BEQ   = 6'd36,
        OP_BNE   = 6'd37,
        OP_BGTZ  = 6'd38
    } op_t;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_BGTZ    = 6'h07;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0A;
    localparam logic [5:0] OPC_ANDI    = 6'h0C;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_NORI    = 6'h0E;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LH      = 6'h21;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_LBU     = 6'h24;
    localparam logic [5:0] OPC_LHU     = 6'h25;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2B;
    localparam logic [5:0] OPC_HALT    = 6'h3F;

    // R-type function codes
    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_JR    = 6'h08;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_NAND  = 6'h28;
    localparam logic [5:0] FN_SLT   = 6'h2A;

    typedef struct packed {
        op_t                operation;
        logic               illegal;
        logic        [4:0]  src_reg;
        logic        [4:0]  tgt_reg;
        logic        [4:0]  dest_reg;
        logic               dest_valid;
        logic        [4:0]  shift_amount;
        logic signed [15:0] imm_signed;
        logic        [15:0] imm_unsigned;
        logic        [25:0] jump_target;
    } dec_t;

    localparam int unsigned INSTR_W = 32;
    localparam int unsigned DEC_W   = $bits(dec_t);

endpackage

@@ sv/mips_dec_instr_if.sv @@
// ----------------------------------------------------------------------------
// mips_dec_instr_if
// Valid/ready channel carrying one raw instruction word.
// ----------------------------------------------------------------------------
interface mips_dec_instr_if;

    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (
        output valid,
        output instruction,
        input  ready
    );

    modport sink (
        input  valid,
        input  instruction,
        output ready
    );

endinterface

@@ sv/mips_dec_result_if.sv @@
// ----------------------------------------------------------------------------
// mips_dec_result_if
// Valid/ready channel carrying one decoded instruction word.
// ----------------------------------------------------------------------------
interface mips_dec_result_if;

    logic               valid;
    logic               ready;
    logic        [5:0]  operation;
    logic               illegal;
    logic        [4:0]  src_reg;
    logic        [4:0]  tgt_reg;
    logic        [4:0]  dest_reg;
    logic               dest_valid;
    logic        [4:0]  shift_amount;
    logic signed [15:0] imm_signed;
    logic        [15:0] imm_unsigned;
    logic        [25:0] jump_target;

    modport source (
        output valid,
        output operation,
        output illegal,
        output src_reg,
        output tgt_reg,
        output dest_reg,
        output dest_valid,
        output shift_amount,
        output imm_signed,
        output imm_unsigned,
        output jump_target,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  illegal,
        input  src_reg,
        input  tgt_reg,
        input  dest_reg,
        input  dest_valid,
        input  shift_amount,
        input  imm_signed,
        input  imm_unsigned,
        input  jump_target,
        output ready
    );

endinterface

@@ sv/mips_dec_stage.sv @@
// ----------------------------------------------------------------------------
// mips_dec_stage
// One valid/ready pipeline register; takes a new word whenever it is empty
// or its current word leaves in the same cycle.
// ----------------------------------------------------------------------------
module mips_dec_stage #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/mips_dec_decode.sv @@
// ----------------------------------------------------------------------------
// mips_dec_decode
// Combinational decode of one instruction word into operation and fields.
// ----------------------------------------------------------------------------
module mips_dec_decode (
    input  logic [31:0]         instruction,
    output mips_dec_pkg::dec_t  result
);

    logic [5:0]        opc;
    logic [5:0]        funct;
    logic [4:0]        rt;
    logic [4:0]        rd;
    logic [4:0]        sh;
    logic              rtype;
    mips_dec_pkg::op_t op;
    logic              bad;

    assign opc   = instruction[31:26];
    assign funct = instruction[5:0];
    assign rt    = instruction[20:16];
    assign rd    = instruction[15:11];
    assign sh    = instruction[10:6];
    assign rtype = (opc == mips_dec_pkg::OPC_SPECIAL);

    always_comb
    begin
        op  = mips_dec_pkg::OP_NOP;
        bad = 1'b0;
        if (rtype)
        begin
            unique case (funct)
                mips_dec_pkg::FN_ADD:   op = mips_dec_pkg::OP_ADD;
                mips_dec_pkg::FN_ADDU:  op = mips_dec_pkg::OP_ADDU;
                mips_dec_pkg::FN_SUB:   op = mips_dec_pkg::OP_SUB;
                mips_dec_pkg::FN_AND:   op = mips_dec_pkg::OP_AND;
                mips_dec_pkg::FN_OR:    op = mips_dec_pkg::OP_OR;
                mips_dec_pkg::FN_XOR:   op = mips_dec_pkg::OP_XOR;
                mips_dec_pkg::FN_NOR:   op = mips_dec_pkg::OP_NOR;
                mips_dec_pkg::FN_NAND:  op = mips_dec_pkg::OP_NAND;
                mips_dec_pkg::FN_SLT:   op = mips_dec_pkg::OP_SLT;
                // shift with rt, rd and shamt all zero is the canonical NOP
                mips_dec_pkg::FN_SLL:   op = ((rt | rd | sh) != 5'd0) ?
                                             mips_dec_pkg::OP_SLL : mips_dec_pkg::OP_NOP;
                mips_dec_pkg::FN_SRL:   op = mips_dec_pkg::OP_SRL;
                mips_dec_pkg::FN_SRA:   op = mips_dec_pkg::OP_SRA;
                mips_dec_pkg::FN_JR:    op = mips_dec_pkg::OP_JR;
                mips_dec_pkg::FN_MULT:  op = mips_dec_pkg::OP_MULT;
                mips_dec_pkg::FN_MULTU: op = mips_dec_pkg::OP_MULTU;
                mips_dec_pkg::FN_MFHI:  op = mips_dec_pkg::OP_MFHI;
                mips_dec_pkg::FN_MFLO:  op = mips_dec_pkg::OP_MFLO;
                default:                bad = 1'b1;
            endcase
        end
        else
        begin
            unique case (opc)
                mips_dec_pkg::OPC_J:     op = mips_dec_pkg::OP_JUMP;
                mips_dec_pkg::OPC_JAL:   op = mips_dec_pkg::OP_JAL;
                mips_dec_pkg::OPC_HALT:  op = mips_dec_pkg::OP_HALT;
                mips_dec_pkg::OPC_ADDI:  op = mips_dec_pkg::OP_ADDI;
                mips_dec_pkg::OPC_ADDIU: op = mips_dec_pkg::OP_ADDIU;
                mips_dec_pkg::OPC_LW:    op = mips_dec_pkg::OP_LW;
                mips_dec_pkg::OPC_LH:    op = mips_dec_pkg::OP_LH;
                mips_dec_pkg::OPC_LHU:   op = mips_dec_pkg::OP_LHU;
                mips_dec_pkg::OPC_LB:    op = mips_dec_pkg::OP_LB;
                mips_dec_pkg::OPC_LBU:   op = mips_dec_pkg::OP_LBU;
                mips_dec_pkg::OPC_SW:    op = mips_dec_pkg::OP_SW;
                mips_dec_pkg::OPC_SH:    op = mips_dec_pkg::OP_SH;
                mips_dec_pkg::OPC_SB:    op = mips_dec_pkg::OP_SB;
                mips_dec_pkg::OPC_LUI:   op = mips_dec_pkg::OP_LUI;
                mips_dec_pkg::OPC_ANDI:  op = mips_dec_pkg::OP_ANDI;
                mips_dec_pkg::OPC_ORI:   op = mips_dec_pkg::OP_ORI;
                mips_dec_pkg::OPC_NORI:  op = mips_dec_pkg::OP_NORI;
                mips_dec_pkg::OPC_SLTI:  op = mips_dec_pkg::OP_SLTI;
                mips_dec_pkg::OPC_BEQ:   op = mips_dec_pkg::OP_BEQ;
                mips_dec_pkg::OPC_BNE:   op = mips_dec_pkg::OP_BNE;
                mips_dec_pkg::OPC_BGTZ:  op = mips_dec_pkg::OP_BGTZ;
                default:                 bad = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        result.operation    = op;
        result.illegal      = bad;
        result.src_reg      = instruction[25:21];
        result.tgt_reg      = rt;
        result.dest_reg     = rtype ? rd : 5'd0;
        result.dest_valid   = rtype;
        result.shift_amount = sh;
        result.imm_signed   = $signed(instruction[15:0]);
        result.imm_unsigned = instruction[15:0];
        result.jump_target  = instruction[25:0];
    end

endmodule

@@ sv/mips_subset_instruction_decoder.sv @@
// ----------------------------------------------------------------------------
// mips_subset_instruction_decoder
// Decodes MIPS subset instruction words (with NAND, NORI, HALT) into an
// operation code, an illegal flag and the unpacked instruction fields.
// ----------------------------------------------------------------------------
//  port    dir   handshake      payload
//  instr   in    valid/ready    instruction[31:0]
//  result  out   valid/ready    operation, illegal, register fields,
//                               shamt, immediates, jump target
//
//  Data path: input register, decode logic, result register.
//  One word per cycle sustained while result is not stalled; decode is a single opcode/funct lookup.
//  Reset clears only the stage valid bits; both stages start empty.
//  A stall on result backs up through the stages; ready drops once both hold.
// ----------------------------------------------------------------------------
module mips_subset_instruction_decoder (
    input  logic              clk,
    input  logic              rst_n,
    mips_dec_instr_if.sink    instr,
    mips_dec_result_if.source result
);

    logic                                   in_stage_valid;
    logic                                   in_stage_ready;
    logic [mips_dec_pkg::INSTR_W-1:0]       in_stage_word;
    mips_dec_pkg::dec_t                     dec;
    logic [mips_dec_pkg::DEC_W-1:0]         out_stage_bits;
    mips_dec_pkg::dec_t                     out_word;

    mips_dec_stage #(
        .WIDTH (mips_dec_pkg::INSTR_W)
    ) u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (instr.ready),
        .in_data   (instr.instruction),
        .out_valid (in_stage_valid),
        .out_ready (in_stage_ready),
        .out_data  (in_stage_word)
    );

    mips_dec_decode u_decode (
        .instruction (in_stage_word),
        .result      (dec)
    );

    mips_dec_stage #(
        .WIDTH (mips_dec_pkg::DEC_W)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stage_valid),
        .in_ready  (in_stage_ready),
        .in_data   (dec),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_stage_bits)
    );

    assign out_word = mips_dec_pkg::dec_t'(out_stage_bits);

    assign result.operation    = out_word.operation;
    assign result.illegal      = out_word.illegal;
    assign result.src_reg      = out_word.src_reg;
    assign result.tgt_reg      = out_word.tgt_reg;
    assign result.dest_reg     = out_word.dest_reg;
    assign result.dest_valid   = out_word.dest_valid;
    assign result.shift_amount = out_word.shift_amount;
    assign result.imm_signed   = out_word.imm_signed;
    assign result.imm_unsigned = out_word.imm_unsigned;
    assign result.jump_target  = out_word.jump_target;

endmodule
